FILE: hdl/lzssd_pkg.sv
// Shared types and constants for the LZSS window decompressor.
// No dependencies; imported by every module of the block.
`default_nettype none

package lzssd_pkg;

    localparam int WIN_DEPTH = 2048;
    localparam int WIN_AW    = 11;

    // The write pointer comes out of reset here; a full clearing sweep that
    // starts here also ends here.
    localparam logic [WIN_AW-1:0] WRITE_START = 11'h7df;
    localparam logic [WIN_AW-1:0] CLEAR_LAST  = 11'h7de;

    localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;
    localparam logic [5:0] MATCH_MIN_LEN  = 6'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LIT,
        ST_READ,
        ST_COPY
    } seq_state_t;

    // Token decoding phase: what the next compressed byte means.
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_MATCH2
    } phase_t;

    // Window memory request from the sequencer.
    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [WIN_AW-1:0] raddr;
    } win_req_t;

    // One decompressed byte handed to the output register.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } emit_t;

endpackage

`default_nettype wire

FILE: hdl/lzssd_window.sv
// History window: 2048 x 8 single-port-write memory with a registered read.
// Depends on lzssd_pkg for the request struct and window sizes.
`default_nettype none

module lzssd_window
    import lzssd_pkg::*;
(
    input  wire logic     aclk,
    input  wire win_req_t req,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [WIN_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/lzssd_seq.sv
// Token decoder and copy sequencer: drives the window port and the emit path.
// Depends on lzssd_pkg; the window memory lives in lzssd_window.
`default_nettype none

module lzssd_seq
    import lzssd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       out_free,
    input  wire logic [7:0] win_rd_data,
    output win_req_t        win_req,
    output emit_t           emit
);

    seq_state_t        state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        flag_bits_reg, flag_bits_next;
    logic [3:0]        flags_left_reg, flags_left_next;
    logic [7:0]        off_low_reg, off_low_next;
    logic [WIN_AW-1:0] wp_reg, wp_next;
    logic [WIN_AW-1:0] rd_addr_reg, rd_addr_next;
    logic [5:0]        count_reg, count_next;
    logic [7:0]        lit_reg, lit_next;
    logic              last_reg, last_next;

    logic              accept;
    logic [3:0]        flags_used;
    phase_t            phase_used;
    logic              copy_done;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign copy_done = (count_reg == 6'd1);

    // Flag consumption after a finished token.
    assign flags_used = (flags_left_reg != 4'd0) ? (flags_left_reg - 4'd1) : 4'd0;
    assign phase_used = (flags_used == 4'd0) ? PH_FLAG : PH_TOKEN;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            phase_reg      <= PH_FLAG;
            flag_bits_reg  <= 8'd0;
            flags_left_reg <= 4'd0;
            off_low_reg    <= 8'd0;
            wp_reg         <= WRITE_START;
            last_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            off_low_reg    <= off_low_next;
            wp_reg         <= wp_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        count_reg   <= count_next;
        lit_reg     <= lit_next;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (wp_reg == CLEAR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (phase_reg == PH_TOKEN && flag_bits_reg[0]) begin
                        state_next = ST_LIT;
                    end else if (phase_reg == PH_MATCH2) begin
                        state_next = ST_READ;
                    end else if (in_last) begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_LIT: begin
                if (out_free) begin
                    state_next = last_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_COPY;
            end
            ST_COPY: begin
                if (out_free) begin
                    if (copy_done) begin
                        state_next = last_reg ? ST_CLEAR : ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Datapath and outputs. The write pointer is stepped by one for clearing,
    // literals and copies alike.
    always_comb begin
        phase_next      = phase_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        off_low_next    = off_low_reg;
        wp_next         = wp_reg;
        rd_addr_next    = rd_addr_reg;
        count_next      = count_reg;
        lit_next        = lit_reg;
        last_next       = last_reg;
        win_req         = '0;
        emit            = '0;
        win_req.waddr   = wp_reg;
        win_req.raddr   = rd_addr_reg;

        case (state_reg)
            ST_CLEAR: begin
                win_req.we    = 1'b1;
                win_req.wdata = 8'd0;
                wp_next       = wp_reg + 11'd1;
            end
            ST_IDLE: begin
                if (accept) begin
                    last_next = in_last;
                    case (phase_reg)
                        PH_TOKEN: begin
                            if (flag_bits_reg[0]) begin
                                lit_next = in_byte;
                            end else begin
                                off_low_next = in_byte;
                                phase_next   = PH_MATCH2;
                            end
                        end
                        PH_MATCH2: begin
                            rd_addr_next = {in_byte[7:5], off_low_reg};
                            count_next   = {1'b0, in_byte[4:0]} + MATCH_MIN_LEN;
                        end
                        default: begin
                            flag_bits_next  = in_byte;
                            flags_left_next = FLAGS_PER_BYTE;
                            phase_next      = PH_TOKEN;
                        end
                    endcase
                    // A stream end on a byte that emits nothing resets at once.
                    if (in_last && !(phase_reg == PH_MATCH2) &&
                        !(phase_reg == PH_TOKEN && flag_bits_reg[0])) begin
                        phase_next      = PH_FLAG;
                        flag_bits_next  = 8'd0;
                        flags_left_next = 4'd0;
                        off_low_next    = 8'd0;
                        wp_next         = WRITE_START;
                    end
                end
            end
            ST_LIT: begin
                if (out_free) begin
                    emit.valid      = 1'b1;
                    emit.data       = lit_reg;
                    emit.last       = 1'b1;
                    win_req.we      = 1'b1;
                    win_req.wdata   = lit_reg;
                    wp_next         = wp_reg + 11'd1;
                    flag_bits_next  = {1'b0, flag_bits_reg[7:1]};
                    flags_left_next = flags_used;
                    phase_next      = phase_used;
                end
            end
            ST_READ: begin
                win_req.re   = 1'b1;
                rd_addr_next = rd_addr_reg + 11'd1;
            end
            ST_COPY: begin
                if (out_free) begin
                    emit.valid    = 1'b1;
                    emit.data     = win_rd_data;
                    emit.last     = copy_done;
                    win_req.we    = 1'b1;
                    win_req.wdata = win_rd_data;
                    wp_next       = wp_reg + 11'd1;
                    count_next    = count_reg - 6'd1;
                    if (copy_done) begin
                        flag_bits_next  = {1'b0, flag_bits_reg[7:1]};
                        flags_left_next = flags_used;
                        phase_next      = phase_used;
                    end
                end
            end
            default: begin
            end
        endcase

        // End of stream after an emitting token: back to reset values.
        if ((state_reg == ST_LIT || (state_reg == ST_COPY && copy_done)) &&
            out_free && last_reg) begin
            phase_next      = PH_FLAG;
            flag_bits_next  = 8'd0;
            flags_left_next = 4'd0;
            off_low_next    = 8'd0;
            wp_next         = WRITE_START;
        end
    end

`ifndef SYNTH
    a_no_emit_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !emit.valid)
        else $error("byte emitted during window clearing");

    a_copy_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (count_reg != 6'd0 && count_reg <= 6'd33))
        else $error("copy count out of range");

    a_copy_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY && $past(state_reg) != ST_COPY) |->
            ($past(state_reg) == ST_READ))
        else $error("copy entered without a window read");

    a_clear_ends_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && $past(state_reg) == ST_CLEAR) |->
            (wp_reg == WRITE_START))
        else $error("clearing sweep left write pointer off start");
`endif

endmodule

`default_nettype wire

FILE: hdl/lzssd_window_decompressor_top_placeholder.sv
// Output register stage for decompressed beats.
// Depends on lzssd_pkg for the emit struct.
`default_nettype none

module lzssd_outreg
    import lzssd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire emit_t emit,
    input  wire logic  m_ready,
    output logic       m_valid,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run,
    output logic       out_free
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (emit.valid) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            byte_reg <= emit.data;
            last_reg <= emit.last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

endmodule

`default_nettype wire

FILE: hdl/lzss_window_decompressor.sv
// Top level of the LZSS decompressor with a 2048-byte history window.
// Depends on lzssd_pkg, lzssd_window, lzssd_seq and lzssd_outreg.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_compressed_byte[7:0], s_last_in
//   m_       out        m_valid / m_ready    m_out_byte[7:0], m_last_of_run
//
// A flag byte or the first byte of a match token is only accepted. A literal
// is accepted, then emitted and stored in the window. A match is accepted,
// then each output byte takes a window read followed by the emit and
// write-back; a match emits 2 to 33 bytes, and s_ready stays low until then.
// After reset, and after any beat with s_last_in set, the window is cleared
// in a sweep over all 2048 entries during which s_ready stays low.
// A stalled output only holds the sequencer; the output register keeps one
// beat so the sequencer can finish its step before m_ready returns.
`default_nettype none

module lzss_window_decompressor
    import lzssd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_compressed_byte,
    input  wire logic       s_last_in,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run
);

    win_req_t   win_req;
    emit_t      emit;
    logic [7:0] win_rd_data;
    logic       out_free;

    // Decoder and sequencer: owns the flag, phase and pointer state.
    lzssd_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_byte     (s_compressed_byte),
        .in_last     (s_last_in),
        .out_free    (out_free),
        .win_rd_data (win_rd_data),
        .win_req     (win_req),
        .emit        (emit)
    );

    // History window; reads and writes never fall in the same cycle, so a
    // match that overlaps its own output sees the bytes it just wrote.
    lzssd_window u_window (
        .aclk    (aclk),
        .req     (win_req),
        .rd_data (win_rd_data)
    );

    // Output register that parts the sequencer from the downstream stall.
    lzssd_outreg u_outreg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .emit          (emit),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .out_free      (out_free)
    );

endmodule

`default_nettype wire
